>>> design/multi_channel_compare_timer_macros.svh
// Assertion macros used by the compare timer core (mcct_core).
`ifndef MULTI_CHANNEL_COMPARE_TIMER_MACROS_SVH
`define MULTI_CHANNEL_COMPARE_TIMER_MACROS_SVH

`ifndef SYNTH

`define MCCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mcct assertion failed");

`define MCCT_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `MCCT_ASSERT(lbl, clk, rstn, !(expr))

`else

`define MCCT_ASSERT(lbl, clk, rstn, prop)

`define MCCT_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

>>> design/mcct_pkg.sv
// Types and constants of the multi-channel compare timer.
package mcct_pkg;

  localparam int Channels  = 3;
  localparam int CountBits = 24;
  localparam int ChIdxW    = (Channels > 1) ? $clog2(Channels) : 1;

  localparam int OpW     = 3;
  localparam int ChanW   = 2;
  localparam int AmountW = 24;
  localparam int UnitW   = 2;

  localparam longint unsigned CountMax = (64'd1 << CountBits) - 64'd1;

  // 32768 ticks per second, 1000 ms per second: 4096/125 ticks per ms
  localparam longint unsigned TicksPerSec = 32768;
  localparam longint unsigned MsPerSec    = 1000;
  localparam longint unsigned MsNum       = TicksPerSec / 8;
  localparam longint unsigned MsDen       = MsPerSec / 8;
  localparam int              MsNumShift  = $clog2(MsNum);
  localparam int              SecShift    = $clog2(TicksPerSec);

  // largest amounts that still convert without saturation
  localparam longint unsigned MsLimit  = (CountMax * MsDen) / MsNum;
  localparam longint unsigned SecLimit = CountMax >> SecShift;
  localparam int              MsAmtW   = $clog2(MsLimit + 64'd1);

  // ceil division by MsDen through a reciprocal multiply
  localparam int              MsNumW  = $clog2(CountMax * MsDen + MsDen);
  localparam int              MsKShift = MsNumW + $clog2(MsDen);
  localparam longint unsigned MsMul   = ((64'd1 << MsKShift) + MsDen - 64'd1) / MsDen;
  localparam int              MsMulW  = $clog2(MsMul + 64'd1);
  localparam int              MsProdW = MsNumW + MsMulW;

  typedef enum logic [OpW-1:0] {
    OpTick      = 3'd0,
    OpStart     = 3'd1,
    OpStop      = 3'd2,
    OpInit      = 3'd3,
    OpArmPeriod = 3'd4,
    OpArmOneShot = 3'd5,
    OpArmDelay  = 3'd6
  } op_e;

  typedef enum logic [UnitW-1:0] {
    UnitTicks = 2'd0,
    UnitMs    = 2'd1,
    UnitSec   = 2'd2
  } unit_e;

  typedef struct packed {
    op_e                  op;
    logic [ChanW-1:0]     channel;
    logic [CountBits-1:0] len;
  } item_t;

  typedef struct packed {
    logic [Channels-1:0]  fired_mask;
    logic                 delay_done;
    logic                 delay_waiting;
    logic [CountBits-1:0] count_value;
  } result_t;

endpackage

>>> design/mcct_if.sv
// Valid/ready channel interfaces for command transactions and results.
interface mcct_in_if;
  logic                         valid;
  logic                         ready;
  logic [mcct_pkg::OpW-1:0]     operation;
  logic [mcct_pkg::ChanW-1:0]   channel;
  logic [mcct_pkg::AmountW-1:0] amount;
  logic [mcct_pkg::UnitW-1:0]   unit;

  modport source (output valid, output operation, output channel, output amount,
                  output unit, input ready);
  modport sink (input valid, input operation, input channel, input amount,
                input unit, output ready);
endinterface

interface mcct_res_if;
  logic                           valid;
  logic                           ready;
  logic [mcct_pkg::Channels-1:0]  fired_mask;
  logic                           delay_done;
  logic                           delay_waiting;
  logic [mcct_pkg::CountBits-1:0] count_value;

  modport source (output valid, output fired_mask, output delay_done,
                  output delay_waiting, output count_value, input ready);
  modport sink (input valid, input fired_mask, input delay_done,
                input delay_waiting, input count_value, output ready);
endinterface

>>> design/mcct_in_stage.sv
// Input register with amount-to-ticks conversion and saturation.
module mcct_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  mcct_in_if.sink             in_i,
  output logic                item_valid_o,
  output mcct_pkg::item_t     item_o,
  input  logic                item_ready_i
);

  logic                                valid_q, valid_d;
  mcct_pkg::item_t                     item_q;
  logic                                accept;
  logic [mcct_pkg::CountBits-1:0]      len;
  logic [mcct_pkg::MsNumW-1:0]         ms_num;
  logic [mcct_pkg::MsProdW-1:0]        ms_prod;
  logic [mcct_pkg::CountBits-1:0]      ms_len;
  logic                                ms_sat;
  logic                                sec_sat;
  logic                                tick_sat;

  assign in_i.ready = !valid_q || item_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // ceil(a * 4096 / 125) = floor((a * 4096 + 124) / 125)
  assign ms_num  = (mcct_pkg::MsNumW'(in_i.amount[mcct_pkg::MsAmtW-1:0])
                    << mcct_pkg::MsNumShift)
                   + mcct_pkg::MsNumW'(mcct_pkg::MsDen - 64'd1);
  assign ms_prod = mcct_pkg::MsProdW'(ms_num)
                   * mcct_pkg::MsProdW'(mcct_pkg::MsMulW'(mcct_pkg::MsMul));
  assign ms_len  = ms_prod[mcct_pkg::MsKShift +: mcct_pkg::CountBits];

  assign ms_sat   = 64'(in_i.amount) > mcct_pkg::MsLimit;
  assign sec_sat  = 64'(in_i.amount) > mcct_pkg::SecLimit;
  assign tick_sat = 64'(in_i.amount) > mcct_pkg::CountMax;

  always_comb begin
    unique case (mcct_pkg::unit_e'(in_i.unit))
      mcct_pkg::UnitMs: begin
        len = ms_sat ? mcct_pkg::CountBits'(mcct_pkg::CountMax) : ms_len;
      end
      mcct_pkg::UnitSec: begin
        len = sec_sat ? mcct_pkg::CountBits'(mcct_pkg::CountMax)
                      : mcct_pkg::CountBits'(64'(in_i.amount) << mcct_pkg::SecShift);
      end
      default: begin
        len = tick_sat ? mcct_pkg::CountBits'(mcct_pkg::CountMax)
                       : mcct_pkg::CountBits'(in_i.amount);
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op      <= mcct_pkg::op_e'(in_i.operation);
      item_q.channel <= in_i.channel;
      item_q.len     <= len;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> design/mcct_core.sv
// Counter, compare channels, delay channel and the result register.
`include "multi_channel_compare_timer_macros.svh"

module mcct_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  mcct_pkg::item_t  item_i,
  output logic             item_ready_o,
  mcct_res_if.source       res_o
);

  logic [mcct_pkg::CountBits-1:0] cnt_q, cnt_d, cnt_inc;
  logic                           run_q, run_d;
  logic [mcct_pkg::CountBits-1:0] cmp_q [mcct_pkg::Channels];
  logic [mcct_pkg::CountBits-1:0] cmp_d [mcct_pkg::Channels];
  logic [mcct_pkg::CountBits-1:0] per_q [mcct_pkg::Channels];
  logic [mcct_pkg::CountBits-1:0] per_d [mcct_pkg::Channels];
  logic [mcct_pkg::Channels-1:0]  single_q, single_d;
  logic [mcct_pkg::Channels-1:0]  armed_q, armed_d;
  logic [mcct_pkg::CountBits-1:0] dcmp_q, dcmp_d;
  logic                           wait_q, wait_d;
  logic [mcct_pkg::Channels-1:0]  fired;
  logic                           done;
  logic                           adv;
  logic                           chan_ok;
  logic [mcct_pkg::ChIdxW-1:0]    idx;
  logic                           out_valid_q, out_valid_d;
  mcct_pkg::result_t              res_q;

  assign item_ready_o = !out_valid_q || res_o.ready;
  assign adv          = item_valid_i && item_ready_o;
  assign cnt_inc      = cnt_q + mcct_pkg::CountBits'(1);
  assign chan_ok      = 32'(item_i.channel) < mcct_pkg::Channels;
  assign idx          = mcct_pkg::ChIdxW'(item_i.channel);

  always_comb begin
    cnt_d    = cnt_q;
    run_d    = run_q;
    cmp_d    = cmp_q;
    per_d    = per_q;
    single_d = single_q;
    armed_d  = armed_q;
    dcmp_d   = dcmp_q;
    wait_d   = wait_q;
    fired    = '0;
    done     = 1'b0;
    if (adv) begin
      unique case (item_i.op)
        mcct_pkg::OpTick: begin
          if (run_q) begin
            cnt_d = cnt_inc;
            if (wait_q && dcmp_q == cnt_inc) begin
              wait_d = 1'b0;
              done   = 1'b1;
            end
            for (int c = 0; c < mcct_pkg::Channels; c++) begin
              if (armed_q[c] && cmp_q[c] == cnt_inc) begin
                fired[c] = 1'b1;
                if (single_q[c]) begin
                  armed_d[c] = 1'b0;
                end else begin
                  cmp_d[c] = cmp_q[c] + per_q[c];
                end
              end
            end
          end
        end
        mcct_pkg::OpStart: begin
          run_d = 1'b1;
        end
        mcct_pkg::OpStop: begin
          run_d = 1'b0;
        end
        mcct_pkg::OpInit: begin
          cnt_d  = '0;
          wait_d = 1'b0;
          run_d  = 1'b1;
        end
        mcct_pkg::OpArmPeriod, mcct_pkg::OpArmOneShot: begin
          if (chan_ok) begin
            per_d[idx]    = item_i.len;
            single_d[idx] = (item_i.op == mcct_pkg::OpArmOneShot);
            armed_d[idx]  = 1'b1;
            cmp_d[idx]    = cnt_q + item_i.len;
          end
        end
        mcct_pkg::OpArmDelay: begin
          dcmp_d = cnt_q + item_i.len;
          wait_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      run_q       <= 1'b0;
      cmp_q       <= '{default: '0};
      per_q       <= '{default: '0};
      single_q    <= '0;
      armed_q     <= '0;
      dcmp_q      <= '0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      cmp_q       <= cmp_d;
      per_q       <= per_d;
      single_q    <= single_d;
      armed_q     <= armed_d;
      dcmp_q      <= dcmp_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.fired_mask    <= fired;
      res_q.delay_done    <= done;
      res_q.delay_waiting <= wait_d;
      res_q.count_value   <= cnt_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.fired_mask    = res_q.fired_mask;
  assign res_o.delay_done    = res_q.delay_done;
  assign res_o.delay_waiting = res_q.delay_waiting;
  assign res_o.count_value   = res_q.count_value;

  `MCCT_ASSERT(a_fire_needs_arm, clk_i, rst_ni, adv |=> ((res_q.fired_mask & ~$past(armed_q)) == '0))
  `MCCT_ASSERT(a_oneshot_disarms, clk_i, rst_ni, adv |=> ((res_q.fired_mask & single_q & armed_q) == '0))
  `MCCT_ASSERT(a_cnt_holds_idle, clk_i, rst_ni, !adv |=> $stable(cnt_q))
  `MCCT_ASSERT(a_fire_on_tick, clk_i, rst_ni, (adv && item_i.op != mcct_pkg::OpTick) |=> (res_q.fired_mask == '0 && !res_q.delay_done))
  `MCCT_ASSERT_NEVER(a_done_and_wait, clk_i, rst_ni, out_valid_q && res_q.delay_done && res_q.delay_waiting)

endmodule

>>> design/multi_channel_compare_timer.sv
// Top level of the multi-channel compare timer.
// Usage:
//   in_i carries command transactions (operation, channel, amount, unit):
//   tick, start, stop, init, arm periodic, arm one-shot, arm delay.
//   res_o returns exactly one result transaction per command: fired_mask,
//   delay_done, delay_waiting and count_value after that command.
// Path: an accepted command passes the input register, then the result
//   register, before its result is offered on res_o.
// Throughput: one command per cycle unless stalled; the counter, the
//   per-channel compare and advance adders and the delay compare all work
//   in one pass between the input register and the result register, and
//   the ms conversion (one reciprocal multiply) precedes the input register.
// Reset: rst_ni clears the counter, stops counting, disarms every channel
//   and clears the delay flag; no result is pending.
// Stall: when res_o.ready is low the result register holds; the input
//   register still takes one more command if empty, after which in_i.ready
//   drops until the result is taken. Nothing is lost or repeated.
module multi_channel_compare_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcct_in_if.sink     in_i,
  mcct_res_if.source  res_o
);

  logic            item_valid;
  logic            item_ready;
  mcct_pkg::item_t item;

  mcct_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  mcct_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_o        (res_o)
  );

endmodule

>>> tb/multi_channel_compare_timer_test.sv
// Self-checking bench for the compare timer: queued commands, timer model, result check.
module multi_channel_compare_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mcct_pkg::OpW-1:0]   OpUnused   = 3'd7;
  localparam logic [mcct_pkg::ChanW-1:0] ChanNone   = 2'd3;
  localparam logic [mcct_pkg::UnitW-1:0] UnitUnused = 2'd3;

  localparam longint unsigned TickMax    = (64'd1 << mcct_pkg::CountBits) - 64'd1;
  localparam longint unsigned MsTicksNum = 4096;
  localparam longint unsigned MsTicksDen = 125;
  localparam longint unsigned SecTicks   = 32768;

  localparam int RandomCmds    = 700;
  localparam int TailCmds      = 100;
  localparam int LongStall     = 60;
  localparam int WatchdogLimit = 500;
  localparam int MaxReports    = 20;

  typedef struct packed {
    logic [mcct_pkg::OpW-1:0]     op;
    logic [mcct_pkg::ChanW-1:0]   channel;
    logic [mcct_pkg::AmountW-1:0] amount;
    logic [mcct_pkg::UnitW-1:0]   unit_sel;
  } command_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cmd_valid = 1'b0;
  command_t cmd = '0;
  logic     res_ready = 1'b0;

  mcct_in_if  in_if ();
  mcct_res_if res_if ();

  assign in_if.valid     = cmd_valid;
  assign in_if.operation = cmd.op;
  assign in_if.channel   = cmd.channel;
  assign in_if.amount    = cmd.amount;
  assign in_if.unit      = cmd.unit_sel;
  assign res_if.ready    = res_ready;

  multi_channel_compare_timer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  always #2 clk = ~clk;

  // timer model state
  logic [mcct_pkg::CountBits-1:0] timer_count = '0;
  bit                             timer_running = 1'b0;
  logic [mcct_pkg::CountBits-1:0] chan_compare [mcct_pkg::Channels] = '{default: '0};
  logic [mcct_pkg::CountBits-1:0] chan_period  [mcct_pkg::Channels] = '{default: '0};
  bit                             chan_oneshot [mcct_pkg::Channels] = '{default: 1'b0};
  bit                             chan_armed   [mcct_pkg::Channels] = '{default: 1'b0};
  logic [mcct_pkg::CountBits-1:0] delay_compare_at = '0;
  bit                             delay_pending = 1'b0;

  command_t          queued_cmds [$];
  mcct_pkg::result_t due_results [$];

  int cmd_total    = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int errors       = 0;
  int fire_cnt     = 0;
  int done_cnt     = 0;
  int stall_cnt    = 0;

  function automatic command_t cmd_of(logic [mcct_pkg::OpW-1:0] op,
                                      logic [mcct_pkg::ChanW-1:0] ch,
                                      logic [mcct_pkg::AmountW-1:0] amt,
                                      logic [mcct_pkg::UnitW-1:0] unit_code);
    command_t c;
    c.op       = op;
    c.channel  = ch;
    c.amount   = amt;
    c.unit_sel = unit_code;
    return c;
  endfunction

  function automatic logic [mcct_pkg::CountBits-1:0] ticks_of(
      logic [mcct_pkg::AmountW-1:0] amt, logic [mcct_pkg::UnitW-1:0] unit_code);
    longint unsigned t;
    t = 64'(amt);
    if (unit_code == mcct_pkg::UnitMs) begin
      t = (t * MsTicksNum + MsTicksDen - 1) / MsTicksDen;
    end else if (unit_code == mcct_pkg::UnitSec) begin
      t = t * SecTicks;
    end
    if (t > TickMax) t = TickMax;
    return t[mcct_pkg::CountBits-1:0];
  endfunction

  task automatic apply_command(input command_t c, output mcct_pkg::result_t r);
    logic [mcct_pkg::CountBits-1:0] len;
    logic [mcct_pkg::Channels-1:0]  fired;
    logic                           done;
    fired = '0;
    done  = 1'b0;
    case (c.op)
      mcct_pkg::OpTick: begin
        if (timer_running) begin
          timer_count = timer_count + 1'b1;
          if (delay_pending && delay_compare_at == timer_count) begin
            delay_pending = 1'b0;
            done = 1'b1;
          end
          for (int i = 0; i < mcct_pkg::Channels; i++) begin
            if (chan_armed[i] && chan_compare[i] == timer_count) begin
              fired[i] = 1'b1;
              if (chan_oneshot[i]) chan_armed[i] = 1'b0;
              else chan_compare[i] = chan_compare[i] + chan_period[i];
            end
          end
        end
      end
      mcct_pkg::OpStart: timer_running = 1'b1;
      mcct_pkg::OpStop:  timer_running = 1'b0;
      mcct_pkg::OpInit: begin
        timer_count   = '0;
        delay_pending = 1'b0;
        timer_running = 1'b1;
      end
      mcct_pkg::OpArmPeriod, mcct_pkg::OpArmOneShot: begin
        if (c.channel < mcct_pkg::Channels) begin
          len = ticks_of(c.amount, c.unit_sel);
          chan_period[c.channel]  = len;
          chan_oneshot[c.channel] = (c.op == mcct_pkg::OpArmOneShot);
          chan_armed[c.channel]   = 1'b1;
          chan_compare[c.channel] = timer_count + len;
        end
      end
      mcct_pkg::OpArmDelay: begin
        delay_compare_at = timer_count + ticks_of(c.amount, c.unit_sel);
        delay_pending    = 1'b1;
      end
      default: ;
    endcase
    r.fired_mask    = fired;
    r.delay_done    = done;
    r.delay_waiting = delay_pending;
    r.count_value   = timer_count;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // command driver
  int send_gap   = 0;
  int send_rate  = 0;
  int send_cycle = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
    end else begin : drive
      mcct_pkg::result_t want;
      if (cmd_valid && in_if.ready) begin
        apply_command(cmd, want);
        due_results.push_back(want);
        accepted_cnt++;
      end
      send_cycle++;
      if (send_cycle % 64 == 0) send_rate = $urandom_range(0, 3);
      if (!cmd_valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_valid <= 1'b0;
        end else if (accepted_cnt + TailCmds < cmd_total && send_rate != 0 &&
                     $urandom_range(0, 7) < send_rate) begin
          send_gap = $urandom_range(0, 4);
          cmd_valid <= 1'b0;
        end else if (queued_cmds.size() > 0) begin
          cmd       <= queued_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int recv_gap      = 0;
  int recv_rate     = 0;
  int recv_cycle    = 0;
  int stall_left    = 0;
  int next_stall_at = 150;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin : monitor
      mcct_pkg::result_t want;
      bit                tail;
      tail = (results_seen + TailCmds >= cmd_total);
      if (res_if.valid && res_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, count %0h", $time,
                   res_if.count_value);
        end else begin
          want = due_results.pop_front();
          fire_cnt += $countones(want.fired_mask);
          done_cnt += int'(want.delay_done);
          compare_field("fired_mask", 32'(want.fired_mask), 32'(res_if.fired_mask));
          compare_field("delay_done", 32'(want.delay_done), 32'(res_if.delay_done));
          compare_field("delay_waiting", 32'(want.delay_waiting),
                        32'(res_if.delay_waiting));
          compare_field("count_value", 32'(want.count_value), 32'(res_if.count_value));
        end
        if (results_seen == next_stall_at && !tail) begin
          stall_left = LongStall;
          stall_cnt++;
          next_stall_at += 300;
        end
      end
      recv_cycle++;
      if (recv_cycle % 64 == 0) recv_rate = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else if (!tail && recv_rate != 0 && $urandom_range(0, 7) < recv_rate) begin
        recv_gap = $urandom_range(0, 4);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_valid && in_if.ready) || (res_if.valid && res_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int                           pick;
    logic [mcct_pkg::AmountW-1:0] short_amt;
    logic [mcct_pkg::UnitW-1:0]   short_unit;
    logic [mcct_pkg::OpW-1:0]     arm_op;

    rst_n = 1'b0;

    // directed: stopped tick, unused codes, saturation, rearm, stop/start, init
    queued_cmds.push_back(cmd_of(mcct_pkg::OpTick, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(OpUnused, ChanNone, 24'hFFFFFF, UnitUnused));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpInit, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmPeriod, 2'd0, 24'd3, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmOneShot, 2'd1, 24'd1, mcct_pkg::UnitMs));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmDelay, 2'd0, 24'hFFFFFF, mcct_pkg::UnitSec));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmDelay, 2'd0, 24'd5, UnitUnused));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmPeriod, ChanNone, 24'd1,
                                 mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmOneShot, 2'd2, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmPeriod, 2'd2, 24'hFFFFFF, mcct_pkg::UnitSec));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmOneShot, 2'd2, 24'hFFFFFF, mcct_pkg::UnitMs));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmPeriod, 2'd2, 24'd2, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpStop, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpTick, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpStart, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    repeat (6) queued_cmds.push_back(cmd_of(mcct_pkg::OpTick, 2'd0, 24'd0,
                                            mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmDelay, 2'd0, 24'd2, mcct_pkg::UnitMs));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpInit, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpArmOneShot, 2'd0, 24'd0, mcct_pkg::UnitTicks));
    queued_cmds.push_back(cmd_of(mcct_pkg::OpTick, 2'd0, 24'd0, mcct_pkg::UnitTicks));

    // random: mostly short arms and running ticks, some noise
    for (int n = 0; n < RandomCmds; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        short_unit = mcct_pkg::UnitMs;
        short_amt  = mcct_pkg::AmountW'($urandom_range(0, 2));
      end else begin
        short_unit = mcct_pkg::UnitTicks;
        short_amt  = mcct_pkg::AmountW'($urandom_range(0, 40));
      end
      arm_op = $urandom_range(0, 1) ? mcct_pkg::OpArmPeriod : mcct_pkg::OpArmOneShot;
      if (pick < 55)
        queued_cmds.push_back(cmd_of(mcct_pkg::OpTick,
                                     mcct_pkg::ChanW'($urandom_range(0, 3)),
                                     mcct_pkg::AmountW'($urandom()),
                                     mcct_pkg::UnitW'($urandom_range(0, 3))));
      else if (pick < 65)
        queued_cmds.push_back(cmd_of(arm_op,
                                     mcct_pkg::ChanW'($urandom_range(0, mcct_pkg::Channels - 1)),
                                     short_amt, short_unit));
      else if (pick < 70)
        queued_cmds.push_back(cmd_of(mcct_pkg::OpArmDelay,
                                     mcct_pkg::ChanW'($urandom_range(0, 3)),
                                     short_amt, short_unit));
      else if (pick < 73)
        queued_cmds.push_back(cmd_of(mcct_pkg::OpStop, 2'd0, 24'd0, mcct_pkg::UnitTicks));
      else if (pick < 77)
        queued_cmds.push_back(cmd_of(mcct_pkg::OpStart, 2'd0, 24'd0, mcct_pkg::UnitTicks));
      else if (pick < 79)
        queued_cmds.push_back(cmd_of(mcct_pkg::OpInit, 2'd0, 24'd0, mcct_pkg::UnitTicks));
      else
        queued_cmds.push_back(cmd_of(mcct_pkg::OpW'($urandom_range(0, 7)),
                                     mcct_pkg::ChanW'($urandom_range(0, 3)),
                                     mcct_pkg::AmountW'($urandom()),
                                     mcct_pkg::UnitW'($urandom_range(0, 3))));
    end
    cmd_total = queued_cmds.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (!(accepted_cnt == cmd_total && due_results.size() == 0)) @(posedge clk);
    repeat (10) @(posedge clk);

    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end

    $display("Summary: %0d commands, %0d results, %0d channel fires, %0d delays completed",
             cmd_total, results_seen, fire_cnt, done_cnt);
    $display("Random idling on both sides, %0d long result stalls, gap-free tail; %0d errors",
             stall_cnt, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
